@@ src/rtmp_chunk_header_parser_core_defines.svh @@
// ----------------------------------------------------------------------------
// rtmp chunk header parser: assertion macros
// concurrent checks for simulation, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef RTMP_CHUNK_HEADER_PARSER_CORE_DEFINES_SVH
`define RTMP_CHUNK_HEADER_PARSER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define RCHP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rchp assertion failed");
`define RCHP_ASSERT_IMP(lbl, ante, cons) \
    `RCHP_ASSERT(lbl, (ante) |-> (cons))
`else
`define RCHP_ASSERT(lbl, prop)
`define RCHP_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

@@ src/rchp_pkg.sv @@
// ----------------------------------------------------------------------------
// rchp_pkg
// shared constants, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package rchp_pkg;

    localparam int TABLE_ENTRIES = 8;
    localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    localparam int MAX_HDR = 14;
    localparam int POS_W = 4;
    localparam int WIN_LEN = 11;
    localparam int STREAM_W = 17;

    localparam logic [STREAM_W-1:0] STREAM_BASE = 17'd64;
    localparam logic [23:0] EXT_TS = 24'hffffff;

    // chunk formats
    localparam logic [1:0] FMT_FULL = 2'd0;
    localparam logic [1:0] FMT_SAME_STREAM = 2'd1;
    localparam logic [1:0] FMT_DELTA_ONLY = 2'd2;
    localparam logic [1:0] FMT_CONT = 2'd3;

    // basic header id escapes
    localparam logic [5:0] ID_TWO_BYTE = 6'd0;
    localparam logic [5:0] ID_THREE_BYTE = 6'd1;

    // result status codes
    localparam logic [1:0] STS_OK = 2'd0;
    localparam logic [1:0] STS_TRUNC = 2'd1;
    localparam logic [1:0] STS_EXT_TS = 2'd2;
    localparam logic [1:0] STS_TABLE_FULL = 2'd3;

    typedef struct packed {
        logic take;
        logic eval;
        logic fin;
        logic ext;
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic active;
        logic ext;
        logic finish;
        logic out_free;
    } sts_t;

    function automatic logic [POS_W-1:0] body_len(input logic [1:0] fmt);
        logic [POS_W-1:0] len;
        case (fmt)
            FMT_FULL: len = 4'd11;
            FMT_SAME_STREAM: len = 4'd7;
            FMT_DELTA_ONLY: len = 4'd3;
            default: len = 4'd0;
        endcase
        return len;
    endfunction

    function automatic logic [1:0] basic_len(input logic [5:0] id6);
        logic [1:0] len;
        case (id6)
            ID_TWO_BYTE: len = 2'd2;
            ID_THREE_BYTE: len = 2'd3;
            default: len = 2'd1;
        endcase
        return len;
    endfunction

endpackage

@@ src/rtmp_chunk_header_parser_core.sv @@
// ----------------------------------------------------------------------------
// rtmp_chunk_header_parser_core
// rtmp chunk header decoder with per-stream header table
// ----------------------------------------------------------------------------
// usage
//   input channel: one stream byte per transfer (data_byte) with header_start
//   marking the first byte of a chunk header; in_valid / in_stall
//   output channel: one decoded header per transfer; out_valid / out_stall;
//   last_of_run marks the final result caused by one input byte
//   a header byte (start or continuation) passes transfer, then evaluate;
//   a byte that completes a header passes transfer, table search, then
//   merge and result load; payload bytes outside a header only transfer
//   a truncated header result is loaded in the transfer cycle itself; results
//   are registered and appear in the cycle after their load
//   the result register takes a new result in the same cycle the previous one
//   transfers out; while the receiver stalls with a result pending, no new
//   byte is taken and a finished header waits in its load state
//   reset clears the parser and all table entries at once; no clearing pass
// ----------------------------------------------------------------------------
module rtmp_chunk_header_parser_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [7:0]                         data_byte,
    input  logic                               header_start,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         status,
    output logic [1:0]                         chunk_format,
    output logic [rchp_pkg::STREAM_W-1:0]      chunk_stream,
    output logic [31:0]                        msg_timestamp,
    output logic [23:0]                        msg_length,
    output logic [7:0]                         msg_type,
    output logic [31:0]                        msg_stream,
    output logic [3:0]                         header_bytes,
    output logic                               last_of_run
);

    rchp_pkg::cmd_t cmd;
    rchp_pkg::sts_t sts;

    rchp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    rchp_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .data_byte     (data_byte),
        .header_start  (header_start),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .chunk_format  (chunk_format),
        .chunk_stream  (chunk_stream),
        .msg_timestamp (msg_timestamp),
        .msg_length    (msg_length),
        .msg_type      (msg_type),
        .msg_stream    (msg_stream),
        .header_bytes  (header_bytes),
        .last_of_run   (last_of_run)
    );

endmodule

@@ src/rchp_dp.sv @@
// ----------------------------------------------------------------------------
// rchp_dp
// header assembly, stream table, field decode and result register
// ----------------------------------------------------------------------------
module rchp_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  rchp_pkg::cmd_t                     cmd,
    output rchp_pkg::sts_t                     sts,
    input  logic [7:0]                         data_byte,
    input  logic                               header_start,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         status,
    output logic [1:0]                         chunk_format,
    output logic [rchp_pkg::STREAM_W-1:0]      chunk_stream,
    output logic [31:0]                        msg_timestamp,
    output logic [23:0]                        msg_length,
    output logic [7:0]                         msg_type,
    output logic [31:0]                        msg_stream,
    output logic [3:0]                         header_bytes,
    output logic                               last_of_run
);

    // header assembly
    logic                              busy_reg, busy_next;
    logic [rchp_pkg::POS_W-1:0]        pos_reg, pos_next;
    logic [1:0]                        basic_reg, basic_next;
    logic [rchp_pkg::POS_W-1:0]        total_reg, total_next;
    logic [7:0]                        hdr_reg [rchp_pkg::MAX_HDR];

    // stream table
    logic                              ent_valid_reg [rchp_pkg::TABLE_ENTRIES];
    logic [rchp_pkg::STREAM_W-1:0]     ent_stream_reg [rchp_pkg::TABLE_ENTRIES];
    logic [31:0]                       ent_ts_reg [rchp_pkg::TABLE_ENTRIES];
    logic [23:0]                       ent_len_reg [rchp_pkg::TABLE_ENTRIES];
    logic [7:0]                        ent_type_reg [rchp_pkg::TABLE_ENTRIES];
    logic [31:0]                       ent_ms_reg [rchp_pkg::TABLE_ENTRIES];

    // lookup result
    logic                              lk_hit_reg;
    logic                              lk_full_reg;
    logic [rchp_pkg::SLOT_W-1:0]       lk_slot_reg;

    // result register
    logic                              out_valid_reg, out_valid_next;
    logic [1:0]                        status_reg, status_next;
    logic [1:0]                        fmt_reg, fmt_next;
    logic [rchp_pkg::STREAM_W-1:0]     stream_reg, stream_next;
    logic [31:0]                       ts_reg, ts_next;
    logic [23:0]                       len_reg, len_next;
    logic [7:0]                        type_reg, type_next;
    logic [31:0]                       ms_reg, ms_next;
    logic [3:0]                        nbytes_reg, nbytes_next;
    logic                              last_reg, last_next;

    logic [1:0]                        cur_fmt;
    logic [5:0]                        cur_id;
    logic [rchp_pkg::STREAM_W-1:0]     cur_stream;
    logic [7:0]                        win [rchp_pkg::WIN_LEN];
    logic [23:0]                       f_delta;
    logic [23:0]                       f_len;
    logic [7:0]                        f_type;
    logic [31:0]                       f_ms;
    logic                              ext_hit;
    logic                              fin_hit;

    logic                              m_found;
    logic [rchp_pkg::SLOT_W-1:0]       m_slot;
    logic                              f_found;
    logic [rchp_pkg::SLOT_W-1:0]       f_slot;

    logic [1:0]                        in_basic;
    logic [rchp_pkg::POS_W-1:0]        in_total;
    logic                              trunc_load;
    logic                              out_free;

    logic [31:0]                       prev_ts;
    logic [23:0]                       prev_len;
    logic [7:0]                        prev_type;
    logic [31:0]                       prev_ms;
    logic [31:0]                       new_ts;
    logic [23:0]                       new_len;
    logic [7:0]                        new_type;
    logic [31:0]                       new_ms;

    // decode of the assembled header
    assign cur_fmt = hdr_reg[0][7:6];
    assign cur_id = hdr_reg[0][5:0];

    always_comb
    begin
        case (cur_id)
            rchp_pkg::ID_TWO_BYTE:
                cur_stream = rchp_pkg::STREAM_BASE + {9'd0, hdr_reg[1]};
            rchp_pkg::ID_THREE_BYTE:
                cur_stream = rchp_pkg::STREAM_BASE + {9'd0, hdr_reg[1]}
                           + {1'b0, hdr_reg[2], 8'h00};
            default:
                cur_stream = {11'd0, cur_id};
        endcase
    end

    always_comb
    begin
        for (int k = 0; k < rchp_pkg::WIN_LEN; k++)
        begin
            case (basic_reg)
                2'd2: win[k] = hdr_reg[k + 2];
                2'd3: win[k] = hdr_reg[k + 3];
                default: win[k] = hdr_reg[k + 1];
            endcase
        end
    end

    assign f_delta = {win[0], win[1], win[2]};
    assign f_len = {win[3], win[4], win[5]};
    assign f_type = win[6];
    assign f_ms = {win[10], win[9], win[8], win[7]};

    assign ext_hit = busy_reg && (cur_fmt == rchp_pkg::FMT_FULL)
                   && (pos_reg == ({2'b00, basic_reg} + 4'd3))
                   && (f_delta == rchp_pkg::EXT_TS);
    assign fin_hit = busy_reg && (pos_reg >= total_reg);

    assign out_free = !out_valid_reg || !out_stall;

    assign sts.busy = busy_reg;
    assign sts.active = header_start || busy_reg;
    assign sts.ext = ext_hit;
    assign sts.finish = fin_hit && !ext_hit;
    assign sts.out_free = out_free;

    // table search: lowest matching entry, else lowest free entry
    always_comb
    begin
        m_found = 1'b0;
        m_slot = '0;
        f_found = 1'b0;
        f_slot = '0;
        for (int i = rchp_pkg::TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (ent_valid_reg[i] && (ent_stream_reg[i] == cur_stream))
            begin
                m_found = 1'b1;
                m_slot = rchp_pkg::SLOT_W'(i);
            end
            if (!ent_valid_reg[i])
            begin
                f_found = 1'b1;
                f_slot = rchp_pkg::SLOT_W'(i);
            end
        end
    end

    // incoming start byte
    assign in_basic = rchp_pkg::basic_len(data_byte[5:0]);
    assign in_total = {2'b00, in_basic} + rchp_pkg::body_len(data_byte[7:6]);
    assign trunc_load = cmd.take && header_start && busy_reg;

    always_comb
    begin
        busy_next = busy_reg;
        pos_next = pos_reg;
        basic_next = basic_reg;
        total_next = total_reg;
        if (cmd.take)
        begin
            if (header_start)
            begin
                busy_next = 1'b1;
                pos_next = 4'd1;
                basic_next = in_basic;
                total_next = in_total;
            end
            else if (busy_reg)
            begin
                pos_next = pos_reg + 4'd1;
            end
        end
        if (cmd.fin || cmd.ext)
        begin
            busy_next = 1'b0;
            pos_next = '0;
        end
    end

    // merge with the previous header of this stream
    always_comb
    begin
        if (lk_hit_reg)
        begin
            prev_ts = ent_ts_reg[lk_slot_reg];
            prev_len = ent_len_reg[lk_slot_reg];
            prev_type = ent_type_reg[lk_slot_reg];
            prev_ms = ent_ms_reg[lk_slot_reg];
        end
        else
        begin
            prev_ts = '0;
            prev_len = '0;
            prev_type = '0;
            prev_ms = '0;
        end
        new_ts = prev_ts;
        new_len = prev_len;
        new_type = prev_type;
        new_ms = prev_ms;
        case (cur_fmt)
            rchp_pkg::FMT_FULL:
            begin
                new_ts = {8'h00, f_delta};
                new_len = f_len;
                new_type = f_type;
                new_ms = f_ms;
            end
            rchp_pkg::FMT_SAME_STREAM:
            begin
                new_ts = prev_ts + {8'h00, f_delta};
                new_len = f_len;
                new_type = f_type;
            end
            rchp_pkg::FMT_DELTA_ONLY:
            begin
                new_ts = prev_ts + {8'h00, f_delta};
            end
            default:
            begin
                new_ts = prev_ts;
            end
        endcase
    end

    // result register loads
    always_comb
    begin
        out_valid_next = out_valid_reg;
        status_next = status_reg;
        fmt_next = fmt_reg;
        stream_next = stream_reg;
        ts_next = ts_reg;
        len_next = len_reg;
        type_next = type_reg;
        ms_next = ms_reg;
        nbytes_next = nbytes_reg;
        last_next = last_reg;
        if (trunc_load)
        begin
            out_valid_next = 1'b1;
            status_next = rchp_pkg::STS_TRUNC;
            fmt_next = cur_fmt;
            stream_next = (pos_reg >= {2'b00, basic_reg}) ? cur_stream : '0;
            ts_next = '0;
            len_next = '0;
            type_next = '0;
            ms_next = '0;
            nbytes_next = pos_reg;
            last_next = (in_total != 4'd1);
        end
        else if (cmd.fin)
        begin
            out_valid_next = 1'b1;
            status_next = lk_full_reg ? rchp_pkg::STS_TABLE_FULL : rchp_pkg::STS_OK;
            fmt_next = cur_fmt;
            stream_next = cur_stream;
            ts_next = new_ts;
            len_next = new_len;
            type_next = new_type;
            ms_next = new_ms;
            nbytes_next = total_reg;
            last_next = 1'b1;
        end
        else if (cmd.ext)
        begin
            out_valid_next = 1'b1;
            status_next = rchp_pkg::STS_EXT_TS;
            fmt_next = rchp_pkg::FMT_FULL;
            stream_next = cur_stream;
            ts_next = {8'h00, rchp_pkg::EXT_TS};
            len_next = '0;
            type_next = '0;
            ms_next = '0;
            nbytes_next = pos_reg;
            last_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < rchp_pkg::TABLE_ENTRIES; i++)
            begin
                ent_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            busy_reg <= busy_next;
            pos_reg <= pos_next;
            out_valid_reg <= out_valid_next;
            if (cmd.fin && !lk_full_reg)
            begin
                ent_valid_reg[lk_slot_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        basic_reg <= basic_next;
        total_reg <= total_next;
        status_reg <= status_next;
        fmt_reg <= fmt_next;
        stream_reg <= stream_next;
        ts_reg <= ts_next;
        len_reg <= len_next;
        type_reg <= type_next;
        ms_reg <= ms_next;
        nbytes_reg <= nbytes_next;
        last_reg <= last_next;
        if (cmd.take)
        begin
            if (header_start)
            begin
                hdr_reg[0] <= data_byte;
            end
            else if (busy_reg && (pos_reg < rchp_pkg::POS_W'(rchp_pkg::MAX_HDR)))
            begin
                hdr_reg[pos_reg] <= data_byte;
            end
        end
        if (cmd.eval)
        begin
            lk_hit_reg <= m_found;
            lk_full_reg <= !m_found && !f_found;
            lk_slot_reg <= m_found ? m_slot : f_slot;
        end
        if (cmd.fin && !lk_full_reg)
        begin
            ent_stream_reg[lk_slot_reg] <= cur_stream;
            ent_ts_reg[lk_slot_reg] <= new_ts;
            ent_len_reg[lk_slot_reg] <= new_len;
            ent_type_reg[lk_slot_reg] <= new_type;
            ent_ms_reg[lk_slot_reg] <= new_ms;
        end
    end

    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign chunk_format = fmt_reg;
    assign chunk_stream = stream_reg;
    assign msg_timestamp = ts_reg;
    assign msg_length = len_reg;
    assign msg_type = type_reg;
    assign msg_stream = ms_reg;
    assign header_bytes = nbytes_reg;
    assign last_of_run = last_reg;

endmodule

@@ src/rchp_ctrl.sv @@
// ----------------------------------------------------------------------------
// rchp_ctrl
// sequencer: byte transfer, header evaluation, result load
// ----------------------------------------------------------------------------
`include "rtmp_chunk_header_parser_core_defines.svh"

module rchp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  rchp_pkg::sts_t   sts,
    output rchp_pkg::cmd_t   cmd
);

    typedef enum logic [3:0] {
        ST_RUN  = 4'b0001,
        ST_EVAL = 4'b0010,
        ST_FIN  = 4'b0100,
        ST_EXT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd = '0;
        in_stall = 1'b1;
        state_next = state_reg;
        case (state_reg)
            ST_RUN:
            begin
                in_stall = !sts.out_free;
                if (in_valid && sts.out_free)
                begin
                    cmd.take = 1'b1;
                    if (sts.active)
                    begin
                        state_next = ST_EVAL;
                    end
                end
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
                if (sts.ext)
                begin
                    state_next = ST_EXT;
                end
                else if (sts.finish)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_RUN;
                end
            end
            ST_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.fin = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_EXT:
            begin
                if (sts.out_free)
                begin
                    cmd.ext = 1'b1;
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `RCHP_ASSERT(a_ext_fin_excl, !(sts.ext && sts.finish))
    `RCHP_ASSERT_IMP(a_eval_after_take, state_reg == ST_EVAL, $past(cmd.take))
    `RCHP_ASSERT_IMP(a_ext_needs_busy, sts.ext, sts.busy)
    `RCHP_ASSERT(a_fin_returns, (state_reg == ST_FIN) |=> (state_reg == ST_FIN || state_reg == ST_RUN))

endmodule

@@ tb/tb_rtmp_chunk_header_parser_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rtmp_chunk_header_parser_core
// drives chunk header byte streams into the parser with random gaps on the
// input and random stalls on the output; a scoreboard decodes every accepted
// byte against its own stream table and checks each result field by field
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [1:0]                    status;
    logic [1:0]                    fmt;
    logic [rchp_pkg::STREAM_W-1:0] stream;
    logic [31:0]                   ts;
    logic [23:0]                   len;
    logic [7:0]                    mtype;
    logic [31:0]                   mstream;
    logic [3:0]                    nbytes;
    logic                          last;
} hdr_result_t;

typedef logic [7:0] byte_q_t[$];

class chunk_header_scoreboard;
    bit                            tab_valid[rchp_pkg::TABLE_ENTRIES];
    logic [rchp_pkg::STREAM_W-1:0] tab_stream[rchp_pkg::TABLE_ENTRIES];
    logic [31:0]                   tab_ts[rchp_pkg::TABLE_ENTRIES];
    logic [23:0]                   tab_len[rchp_pkg::TABLE_ENTRIES];
    logic [7:0]                    tab_type[rchp_pkg::TABLE_ENTRIES];
    logic [31:0]                   tab_ms[rchp_pkg::TABLE_ENTRIES];
    logic [7:0]                    asm_bytes[rchp_pkg::MAX_HDR];
    bit                            busy;
    int                            pos;
    int                            basic_len;
    int                            total_len;
    hdr_result_t                   pending_headers[$];
    int                            errors;

    function new();
        foreach (tab_valid[i])
        begin
            tab_valid[i] = 1'b0;
            tab_stream[i] = '0;
            tab_ts[i] = '0;
            tab_len[i] = '0;
            tab_type[i] = '0;
            tab_ms[i] = '0;
        end
        foreach (asm_bytes[i])
            asm_bytes[i] = 8'h00;
        busy = 1'b0;
        pos = 0;
        basic_len = 0;
        total_len = 0;
        errors = 0;
    endfunction

    function int pending();
        return pending_headers.size();
    endfunction

    function logic [23:0] field24(int off);
        return {asm_bytes[off], asm_bytes[off + 1], asm_bytes[off + 2]};
    endfunction

    function logic [rchp_pkg::STREAM_W-1:0] decoded_stream();
        case (asm_bytes[0][5:0])
            rchp_pkg::ID_TWO_BYTE: return rchp_pkg::STREAM_BASE + asm_bytes[1];
            rchp_pkg::ID_THREE_BYTE:
                return rchp_pkg::STREAM_BASE + asm_bytes[1] + {asm_bytes[2], 8'h00};
            default: return {11'd0, asm_bytes[0][5:0]};
        endcase
    endfunction

    // table lookup or claim, merge omitted fields, write back
    function hdr_result_t resolve_header();
        hdr_result_t                   r;
        int                            slot;
        int                            off;
        logic [1:0]                    fmt;
        logic [rchp_pkg::STREAM_W-1:0] sid;
        logic [31:0]                   ts;
        logic [23:0]                   len;
        logic [7:0]                    mt;
        logic [31:0]                   ms;
        r = '0;
        r.status = rchp_pkg::STS_OK;
        fmt = asm_bytes[0][7:6];
        sid = decoded_stream();
        off = basic_len;
        slot = -1;
        ts = '0;
        len = '0;
        mt = '0;
        ms = '0;
        for (int i = 0; i < rchp_pkg::TABLE_ENTRIES; i++)
            if (slot < 0 && tab_valid[i] && tab_stream[i] == sid)
                slot = i;
        if (slot < 0)
        begin
            for (int i = 0; i < rchp_pkg::TABLE_ENTRIES; i++)
                if (slot < 0 && !tab_valid[i])
                    slot = i;
            if (slot >= 0)
            begin
                tab_valid[slot] = 1'b1;
                tab_stream[slot] = sid;
                tab_ts[slot] = '0;
                tab_len[slot] = '0;
                tab_type[slot] = '0;
                tab_ms[slot] = '0;
            end
            else
                r.status = rchp_pkg::STS_TABLE_FULL;
        end
        if (slot >= 0)
        begin
            ts = tab_ts[slot];
            len = tab_len[slot];
            mt = tab_type[slot];
            ms = tab_ms[slot];
        end
        case (fmt)
            rchp_pkg::FMT_FULL:
            begin
                ts = {8'h00, field24(off)};
                len = field24(off + 3);
                mt = asm_bytes[off + 6];
                ms = {asm_bytes[off + 10], asm_bytes[off + 9], asm_bytes[off + 8],
                      asm_bytes[off + 7]};
            end
            rchp_pkg::FMT_SAME_STREAM:
            begin
                ts = ts + {8'h00, field24(off)};
                len = field24(off + 3);
                mt = asm_bytes[off + 6];
            end
            rchp_pkg::FMT_DELTA_ONLY:
                ts = ts + {8'h00, field24(off)};
            default:
            begin
            end
        endcase
        if (slot >= 0)
        begin
            tab_ts[slot] = ts;
            tab_len[slot] = len;
            tab_type[slot] = mt;
            tab_ms[slot] = ms;
        end
        r.fmt = fmt;
        r.stream = sid;
        r.ts = ts;
        r.len = len;
        r.mtype = mt;
        r.mstream = ms;
        r.nbytes = 4'(total_len);
        return r;
    endfunction

    function void note_byte(logic [7:0] value, logic first);
        hdr_result_t batch[$];
        hdr_result_t r;
        if (first)
        begin
            if (busy)
            begin
                r = '0;
                r.status = rchp_pkg::STS_TRUNC;
                r.fmt = asm_bytes[0][7:6];
                r.stream = (pos >= basic_len) ? decoded_stream() : '0;
                r.nbytes = 4'(pos);
                batch.push_back(r);
            end
            foreach (asm_bytes[i])
                asm_bytes[i] = 8'h00;
            asm_bytes[0] = value;
            case (value[5:0])
                rchp_pkg::ID_TWO_BYTE: basic_len = 2;
                rchp_pkg::ID_THREE_BYTE: basic_len = 3;
                default: basic_len = 1;
            endcase
            case (value[7:6])
                rchp_pkg::FMT_FULL: total_len = basic_len + 11;
                rchp_pkg::FMT_SAME_STREAM: total_len = basic_len + 7;
                rchp_pkg::FMT_DELTA_ONLY: total_len = basic_len + 3;
                default: total_len = basic_len;
            endcase
            pos = 1;
            busy = 1'b1;
        end
        else if (busy)
        begin
            if (pos < rchp_pkg::MAX_HDR)
                asm_bytes[pos] = value;
            pos++;
        end
        if (busy)
        begin
            if (asm_bytes[0][7:6] == rchp_pkg::FMT_FULL && pos == basic_len + 3 &&
                field24(basic_len) == rchp_pkg::EXT_TS)
            begin
                r = '0;
                r.status = rchp_pkg::STS_EXT_TS;
                r.fmt = rchp_pkg::FMT_FULL;
                r.stream = decoded_stream();
                r.ts = {8'h00, rchp_pkg::EXT_TS};
                r.nbytes = 4'(pos);
                batch.push_back(r);
                busy = 1'b0;
                pos = 0;
            end
            else if (pos >= total_len)
            begin
                batch.push_back(resolve_header());
                busy = 1'b0;
                pos = 0;
            end
        end
        if (batch.size() > 0)
        begin
            r = batch.pop_back();
            r.last = 1'b1;
            batch.push_back(r);
            foreach (batch[i])
                pending_headers.push_back(batch[i]);
        end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    function void check_header(hdr_result_t got);
        hdr_result_t want;
        if (pending_headers.size() == 0)
        begin
            $error("unexpected result: status %0d chunk_stream %0d", got.status, got.stream);
            errors++;
            return;
        end
        want = pending_headers.pop_front();
        compare_field("status", want.status, got.status);
        compare_field("chunk_format", want.fmt, got.fmt);
        compare_field("chunk_stream", want.stream, got.stream);
        compare_field("msg_timestamp", want.ts, got.ts);
        compare_field("msg_length", want.len, got.len);
        compare_field("msg_type", want.mtype, got.mtype);
        compare_field("msg_stream", want.mstream, got.mstream);
        compare_field("header_bytes", want.nbytes, got.nbytes);
        compare_field("last_of_run", want.last, got.last);
    endfunction
endclass

module tb_rtmp_chunk_header_parser_core;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int ITEM_BYTES = 1250;
    localparam int WRAP_HEADERS = 258;
    localparam int POOL_SIZE = 10;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic [7:0]                    data_byte;
    logic                          header_start;
    logic                          out_valid;
    logic                          out_stall;
    logic [1:0]                    status;
    logic [1:0]                    chunk_format;
    logic [rchp_pkg::STREAM_W-1:0] chunk_stream;
    logic [31:0]                   msg_timestamp;
    logic [23:0]                   msg_length;
    logic [7:0]                    msg_type;
    logic [31:0]                   msg_stream;
    logic [3:0]                    header_bytes;
    logic                          last_of_run;

    chunk_header_scoreboard sb = new();
    hdr_result_t            seen;
    int unsigned            cycle_count = 0;
    int                     sent_bytes = 0;
    int                     stall_left = 0;
    bit                     in_quiet = 1'b0;
    bit                     out_quiet = 1'b0;
    int unsigned            stream_pool[POOL_SIZE];

    rtmp_chunk_header_parser_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .data_byte(data_byte),
        .header_start(header_start),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .chunk_format(chunk_format),
        .chunk_stream(chunk_stream),
        .msg_timestamp(msg_timestamp),
        .msg_length(msg_length),
        .msg_type(msg_type),
        .msg_stream(msg_stream),
        .header_bytes(header_bytes),
        .last_of_run(last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_byte(data_byte, header_start);
            if (out_valid && !out_stall)
            begin
                seen = {status, chunk_format, chunk_stream, msg_timestamp, msg_length,
                        msg_type, msg_stream, header_bytes, last_of_run};
                sb.check_header(seen);
            end
        end
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        else if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // receiver stalls
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 199) == 0)
                out_quiet = !out_quiet;
            if (stall_left > 0)
            begin
                out_stall = 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall = 1'b0;
                if (!out_quiet && $urandom_range(0, 3) == 0)
                    stall_left = idle_len();
            end
        end
    end

    // basic header in the shortest or a random legal form, then the body
    function automatic byte_q_t chunk_bytes(input logic [1:0] fmt, input int unsigned sid,
                                            input logic [23:0] ts, input logic [23:0] len,
                                            input logic [7:0] mt, input logic [31:0] ms);
        byte_q_t     q;
        logic [15:0] ext;
        if (sid < 64)
            q.push_back({fmt, 6'(sid)});
        else
        begin
            ext = 16'(sid - 64);
            if (ext < 256 && $urandom_range(0, 1) == 1)
            begin
                q.push_back({fmt, rchp_pkg::ID_TWO_BYTE});
                q.push_back(ext[7:0]);
            end
            else
            begin
                q.push_back({fmt, rchp_pkg::ID_THREE_BYTE});
                q.push_back(ext[7:0]);
                q.push_back(ext[15:8]);
            end
        end
        if (fmt != rchp_pkg::FMT_CONT)
        begin
            q.push_back(ts[23:16]);
            q.push_back(ts[15:8]);
            q.push_back(ts[7:0]);
        end
        if (fmt == rchp_pkg::FMT_FULL || fmt == rchp_pkg::FMT_SAME_STREAM)
        begin
            q.push_back(len[23:16]);
            q.push_back(len[15:8]);
            q.push_back(len[7:0]);
            q.push_back(mt);
        end
        if (fmt == rchp_pkg::FMT_FULL)
        begin
            q.push_back(ms[7:0]);
            q.push_back(ms[15:8]);
            q.push_back(ms[23:16]);
            q.push_back(ms[31:24]);
        end
        return q;
    endfunction

    task automatic send_byte(input logic [7:0] value, input logic first);
        int gap;
        gap = (in_quiet || $urandom_range(0, 9) < 6) ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            data_byte = 8'($urandom);
            header_start = 1'($urandom);
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        data_byte = value;
        header_start = first;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_bytes(input byte_q_t q);
        foreach (q[i])
            send_byte(q[i], i == 0);
        sent_bytes += q.size();
    endtask

    initial
    begin
        byte_q_t     q;
        logic [1:0]  fmt;
        int unsigned sid;
        logic [23:0] ts;
        logic [23:0] len;
        int          r;
        int          keep;

        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = 8'h00;
        header_start = 1'b0;
        stream_pool = '{2, 63, 64, 319, 320, 65599, 0, 0, 0, 0};
        for (int i = 6; i < POOL_SIZE; i++)
            stream_pool[i] = $urandom_range(2, 65599);
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: all formats, extremes, truncation, extended timestamp, idle payload
        send_bytes(chunk_bytes(rchp_pkg::FMT_FULL, 63, 24'hfffffe, 24'hffffff, 8'hff,
                               32'hffffffff));
        send_bytes(chunk_bytes(rchp_pkg::FMT_DELTA_ONLY, 63, 24'h000001, '0, '0, '0));
        send_bytes(chunk_bytes(rchp_pkg::FMT_SAME_STREAM, 2, 24'hffffff, 24'h000000, 8'h00,
                               '0));
        send_byte({rchp_pkg::FMT_CONT, rchp_pkg::ID_THREE_BYTE}, 1'b1);
        send_byte(8'hff, 1'b0);
        send_byte({rchp_pkg::FMT_CONT, 6'd63}, 1'b1);
        send_bytes(chunk_bytes(rchp_pkg::FMT_FULL, 64, rchp_pkg::EXT_TS, 24'h123456, 8'h5a,
                               32'h89abcdef));
        send_byte(8'ha5, 1'b0);

        // long run of large deltas on one stream to wrap the timestamp
        repeat (WRAP_HEADERS)
        begin
            if ($urandom_range(0, 19) == 0)
                in_quiet = !in_quiet;
            send_bytes(chunk_bytes(rchp_pkg::FMT_DELTA_ONLY, 63,
                                   24'($urandom_range(24'hfe0000, 24'hffffff)),
                                   '0, '0, '0));
        end

        while (sent_bytes < ITEM_BYTES)
        begin
            fmt = 2'($urandom_range(0, 3));
            sid = stream_pool[$urandom_range(0, POOL_SIZE - 1)];
            case ($urandom_range(0, 19))
                0: ts = rchp_pkg::EXT_TS;
                1: ts = 24'h000000;
                2: ts = 24'hfffffe;
                default: ts = 24'($urandom);
            endcase
            case ($urandom_range(0, 9))
                0: len = 24'h000000;
                1: len = 24'hffffff;
                default: len = 24'($urandom);
            endcase
            q = chunk_bytes(fmt, sid, ts, len, 8'($urandom), $urandom);
            r = $urandom_range(0, 99);
            if (r < 5)
            begin
                send_byte(8'($urandom), 1'($urandom));
                sent_bytes++;
            end
            else
            begin
                if (r < 13 && q.size() > 1)
                begin
                    keep = $urandom_range(1, q.size() - 1);
                    while (q.size() > keep)
                        void'(q.pop_back());
                end
                send_bytes(q);
                if (r >= 13 && $urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 4))
                        send_byte(8'($urandom), 1'b0);
            end
            if ($urandom_range(0, 9) == 0)
                in_quiet = !in_quiet;
        end

        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/rchp_pkg.sv
src/rchp_dp.sv
src/rchp_ctrl.sv
src/rtmp_chunk_header_parser_core.sv
tb/tb_rtmp_chunk_header_parser_core.sv
